// ----- rtl/core/bounded_sequence_store_assert.svh -----
// Assertion macros for the bounded sequence store.
// Used by bounded_sequence_store.sv; expects signals clk and rst_n in scope.
`ifndef BOUNDED_SEQUENCE_STORE_ASSERT_SVH
`define BOUNDED_SEQUENCE_STORE_ASSERT_SVH

// invariant, checked every cycle out of reset
`define BSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bss_pkg.sv -----
// Package for the bounded sequence store: word types, action and status codes,
// cell operations and controller states. No dependencies.
`default_nettype none

package bss_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int POS_BITS      = 8;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_BACK  = 3'd1;
  localparam logic [2:0] ACT_REMOVE    = 3'd2;
  localparam logic [2:0] ACT_READ      = 3'd3;
  localparam logic [2:0] ACT_FIND      = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]          action;
    logic [31:0]         value;
    logic [POS_BITS-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value_res;
    logic [3:0]  position_res;
    logic [1:0]  status;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FRONT,
    CELL_LOAD,
    CELL_REMOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_SCAN
  } bss_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/bss_cell.sv -----
// One storage cell of the sequence chain: holds one entry, shifts to/from
// its neighbors and compares against the search key. Depends on bss_pkg.
`default_nettype none

module bss_cell import bss_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int IW        = 4,
  parameter int IDX       = 0
) (
  input  wire logic                 clk,
  input  wire cell_op_t             op,
  input  wire logic [IW-1:0]        sel,
  input  wire logic [WORD_BITS-1:0] ins_word,
  input  wire logic [WORD_BITS-1:0] lower_word,
  input  wire logic [WORD_BITS-1:0] upper_word,
  input  wire logic [WORD_BITS-1:0] key,
  output logic      [WORD_BITS-1:0] word,
  output logic                      match
);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    unique case (op)
      CELL_HOLD:   word_nxt = word_r;
      CELL_FRONT:  word_nxt = (IDX == 0) ? ins_word : lower_word;
      CELL_LOAD:   word_nxt = (IW'(IDX) == sel) ? ins_word : word_r;
      CELL_REMOVE: word_nxt = (IW'(IDX) >= sel) ? upper_word : word_r;
      default:     word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word  = word_r;
  assign match = (word_r == key);

endmodule

`default_nettype wire

// ----- rtl/core/bss_mod.sv -----
// Bit-serial remainder unit: position modulo count, one dividend bit per cycle.
// Depends on bss_pkg.
`default_nettype none

module bss_mod import bss_pkg::*; #(
  parameter int CW = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [POS_BITS-1:0] dividend,
  input  wire logic [CW-1:0]       divisor,
  output logic                     busy,
  output logic      [CW-1:0]       rem
);

  localparam int SW = $clog2(POS_BITS);

  logic                busy_r;
  logic [SW-1:0]       step_r;
  logic [CW-1:0]       rem_r;
  logic [POS_BITS-1:0] dvd_r;
  logic [CW:0]         trial;
  logic [CW:0]         diff;

  assign trial = {rem_r, dvd_r[POS_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == SW'(POS_BITS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= (trial >= {1'b0, divisor}) ? diff[CW-1:0] : trial[CW-1:0];
      dvd_r <= {dvd_r[POS_BITS-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/bounded_sequence_store.sv -----
// Bounded sequence store top level: controller, chain of storage cells,
// remainder unit and result register. Depends on bss_pkg, bss_cell, bss_mod.
//
//   channel | ports                        | payload
//   --------+------------------------------+-----------
//   input   | in_valid, in_ready, in_data  | in_word_t
//   result  | out_valid, out_ready, out_data | out_word_t
//
// Insert answers from the decode state; read/remove wait for the bit-serial
// position modulo count; find scans up to the last match. A result stall
// holds the controller; the result register lets the next word in while
// the last result waits. Reset clears state, count and out_valid only.
`default_nettype none

module bounded_sequence_store import bss_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bss_state_t           state_r, state_nxt;
  logic [2:0]           act_r;
  logic [WORD_BITS-1:0] word_r;
  logic [POS_BITS-1:0]  pos_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [DEPTH-1:0]     match_r, match_nxt;
  out_word_t            out_r, out_nxt;
  logic                 out_valid_r;
  logic                 load_out;

  cell_op_t             cell_op;
  logic [IW-1:0]        cell_sel;
  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic [DEPTH-1:0]     cell_match;
  logic [DEPTH-1:0]     match_live;

  logic                 mod_start;
  logic                 mod_busy;
  logic [CW-1:0]        mod_rem;
  logic [IW-1:0]        p_idx;

  logic                 out_free;
  logic                 full;
  logic                 is_insert;
  logic [DEPTH-1:0]     match_rest;
  logic [31:0]          word_ext;
  logic [31:0]          rd_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign is_insert = (act_r == ACT_INS_FRONT) || (act_r == ACT_INS_BACK);
  assign p_idx     = IW'(mod_rem);
  assign word_ext  = 32'(word_r);
  assign rd_ext    = 32'(cell_word[p_idx]);
  assign match_rest = match_r & ~(DEPTH'(1) << idx_r);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bss_cell #(
      .WORD_BITS (WORD_BITS),
      .IW        (IW),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .sel        (cell_sel),
      .ins_word   (word_r),
      .lower_word (cell_word[(i == 0) ? 0 : i - 1]),
      .upper_word (cell_word[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
      .key        (word_r),
      .word       (cell_word[i]),
      .match      (cell_match[i])
    );
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_live[i] = cell_match[i] && (CW'(i) < count_r);
    end
  end

  bss_mod #(
    .CW (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (pos_r),
    .divisor  (count_r),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (act_r)
          ACT_INS_FRONT, ACT_INS_BACK: begin
            if (out_free) state_nxt = S_IDLE;
          end
          ACT_REMOVE, ACT_READ, ACT_FIND: begin
            if (count_r == '0) begin
              if (out_free) state_nxt = S_IDLE;
            end else if (act_r == ACT_FIND) begin
              if (match_live != '0) state_nxt = S_SCAN;
              else if (out_free)    state_nxt = S_IDLE;
            end else begin
              state_nxt = S_MOD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MOD: begin
        if (!mod_busy && out_free) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (match_r[idx_r] && out_free && match_rest == '0) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    cell_op   = CELL_HOLD;
    cell_sel  = '0;
    load_out  = 1'b0;
    out_nxt   = out_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    match_nxt = match_r;
    mod_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
      end
      S_DECODE: begin
        unique case (act_r)
          ACT_INS_FRONT, ACT_INS_BACK: begin
            if (out_free) begin
              load_out = 1'b1;
              if (full) begin
                out_nxt = '{value_res: word_ext, position_res: 4'd0,
                            status: STAT_FULL, last: 1'b1};
              end else begin
                out_nxt = '{value_res: word_ext,
                            position_res: (act_r == ACT_INS_FRONT) ? 4'd0 : 4'(count_r),
                            status: STAT_OK, last: 1'b1};
                cell_op   = (act_r == ACT_INS_FRONT) ? CELL_FRONT : CELL_LOAD;
                cell_sel  = IW'(count_r);
                count_nxt = count_r + 1'b1;
              end
            end
          end
          ACT_REMOVE, ACT_READ, ACT_FIND: begin
            if (count_r == '0) begin
              if (out_free) begin
                load_out = 1'b1;
                out_nxt  = '{value_res: 32'd0, position_res: 4'd0,
                             status: STAT_EMPTY, last: 1'b1};
              end
            end else if (act_r == ACT_FIND) begin
              match_nxt = match_live;
              if (match_live == '0 && out_free) begin
                load_out = 1'b1;
                out_nxt  = '{value_res: word_ext, position_res: 4'd0,
                             status: STAT_NOT_FOUND, last: 1'b1};
              end
            end else begin
              mod_start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_MOD: begin
        if (!mod_busy && out_free) begin
          load_out = 1'b1;
          out_nxt  = '{value_res: rd_ext, position_res: 4'(p_idx),
                       status: STAT_OK, last: 1'b1};
          if (act_r == ACT_REMOVE) begin
            cell_op   = CELL_REMOVE;
            cell_sel  = p_idx;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (match_r[idx_r]) begin
          if (out_free) begin
            load_out  = 1'b1;
            out_nxt   = '{value_res: word_ext, position_res: 4'(idx_r),
                          status: STAT_OK, last: (match_rest == '0)};
            match_nxt = match_rest;
            idx_nxt   = idx_r + 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r  <= in_data.action;
      word_r <= WORD_BITS'(in_data.value);
      pos_r  <= in_data.position;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
    idx_r   <= idx_nxt;
    match_r <= match_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "bounded_sequence_store_assert.svh"

  `BSS_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "count above depth")
  `BSS_ASSERT_IMP(a_mod_idle, state_r == S_IDLE, !mod_busy, "remainder unit busy while idle")
  `BSS_ASSERT_IMP(a_scan_match, state_r == S_SCAN, match_r != '0, "scan without pending match")
  `BSS_ASSERT_NEXT(a_insert_count,
    state_r == S_DECODE && is_insert && out_free && !full,
    count_r == CW'($past(count_r) + 1'b1), "insert did not grow count")

endmodule

`default_nettype wire

// ----- sim/bounded_sequence_store_tb.sv -----
// Self-checking testbench for bounded_sequence_store: directed and random actions,
// results checked in order against a behavioral copy of the store.
// Depends on bss_pkg and bounded_sequence_store.
`timescale 1ns / 100ps

module bounded_sequence_store_tb;
  import bss_pkg::*;

  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 90;
  localparam int SETTLE_CYCLES = 64;

  class store_tracker;
    logic [31:0] words [DEPTH_DEF];
    int          used;
    int          mismatches;
    int          seen;
    out_word_t   pending_results [$];

    function new();
      used = 0;
      mismatches = 0;
      seen = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH %s", msg);
      mismatches++;
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction

    function void queue_result(out_word_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void take_action(in_word_t w);
      out_word_t r;
      int p;
      int i;
      int hits;
      int k;
      r = '0;
      r.last = 1'b1;
      case (w.action)
        ACT_INS_FRONT, ACT_INS_BACK: begin
          r.value_res = w.value;
          if (used == DEPTH_DEF) begin
            r.status = STAT_FULL;
          end else if (w.action == ACT_INS_FRONT) begin
            for (i = used; i > 0; i--) words[i] = words[i-1];
            words[0] = w.value;
            used++;
          end else begin
            r.position_res = used[3:0];
            words[used] = w.value;
            used++;
          end
          queue_result(r);
        end
        ACT_REMOVE, ACT_READ: begin
          if (used == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            p = int'(w.position) % used;
            r.value_res = words[p];
            r.position_res = p[3:0];
            if (w.action == ACT_REMOVE) begin
              for (i = p; i + 1 < used; i++) words[i] = words[i+1];
              used--;
            end
          end
          queue_result(r);
        end
        ACT_FIND: begin
          if (used == 0) begin
            r.status = STAT_EMPTY;
            queue_result(r);
          end else begin
            hits = 0;
            for (i = 0; i < used; i++) if (words[i] == w.value) hits++;
            r.value_res = w.value;
            if (hits == 0) begin
              r.status = STAT_NOT_FOUND;
              queue_result(r);
            end else begin
              k = 0;
              for (i = 0; i < used; i++) begin
                if (words[i] == w.value) begin
                  k++;
                  r.position_res = i[3:0];
                  r.last = (k == hits);
                  queue_result(r);
                end
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("word %0d: unexpected, val %h pos %0d st %0d last %0d", seen,
                         got.value_res, got.position_res, got.status, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.value_res !== want.value_res || got.position_res !== want.position_res ||
          got.status !== want.status || got.last !== want.last)
        report($sformatf("word %0d: got val %h pos %0d st %0d last %0d, want %h %0d %0d %0d",
                         seen, got.value_res, got.position_res, got.status, got.last,
                         want.value_res, want.position_res, want.status, want.last));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      no_idle = 1'b0;

  store_tracker sb = new();
  logic [31:0]  value_pool [4];

  bounded_sequence_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= no_idle || ($urandom_range(0, 99) >= 19);
  end

  task automatic send_word(input in_word_t w);
    while (!no_idle && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_action(w);
  endtask

  task automatic send_action(input logic [2:0] act, input logic [31:0] val,
                             input logic [7:0] pos);
    in_word_t w;
    w.action = act;
    w.value = val;
    w.position = pos;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic in_word_t pick_word(input bit growing);
    in_word_t w;
    int roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) w.value = value_pool[$urandom_range(0, 3)];
    else w.value = $urandom();
    if ($urandom_range(0, 1) != 0) w.position = 8'($urandom_range(0, 15));
    else w.position = 8'($urandom_range(0, 255));
    if (growing) begin
      if (roll < 30) w.action = ACT_INS_BACK;
      else if (roll < 55) w.action = ACT_INS_FRONT;
      else if (roll < 70) w.action = ACT_READ;
      else if (roll < 90) w.action = ACT_FIND;
      else w.action = ACT_REMOVE;
    end else begin
      if (roll < 45) w.action = ACT_REMOVE;
      else if (roll < 52) w.action = ACT_INS_BACK;
      else if (roll < 60) w.action = ACT_INS_FRONT;
      else if (roll < 75) w.action = ACT_READ;
      else w.action = ACT_FIND;
    end
    return w;
  endfunction

  initial begin
    int  k;
    int  real_items;
    bit  growing;
    in_word_t w;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = $urandom();
    value_pool[3] = $urandom();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store and spare codes, then two inserts, a read and two finds
    send_action(ACT_READ, 32'h0, 8'hFF);
    send_action(ACT_REMOVE, 32'h0, 8'h00);
    send_action(ACT_FIND, 32'h0, 8'h00);
    send_action(ACT_SPARE_5, 32'hFFFF_FFFF, 8'hFF);
    send_action(ACT_SPARE_6, 32'h0, 8'h00);
    send_action(ACT_SPARE_7, 32'h1234_5678, 8'h55);
    send_action(ACT_INS_BACK, 32'h0000_0000, 8'h00);
    send_action(ACT_INS_FRONT, 32'hFFFF_FFFF, 8'hFF);
    send_action(ACT_READ, 32'h0, 8'hFF);
    send_action(ACT_FIND, 32'h0000_0000, 8'h00);
    send_action(ACT_FIND, 32'h1234_5678, 8'h00);
    // fill to full with repeated words, two inserts when full, a find and two removes
    for (k = 0; k < DEPTH_DEF - 2; k++)
      send_action(k[0] ? ACT_INS_BACK : ACT_INS_FRONT,
                  (k % 3 == 0) ? 32'hA5A5_A5A5 : $urandom(), 8'(k));
    send_action(ACT_INS_FRONT, 32'h5A5A_5A5A, 8'h00);
    send_action(ACT_INS_BACK, 32'h5A5A_5A5A, 8'h00);
    send_action(ACT_FIND, 32'hA5A5_A5A5, 8'h00);
    send_action(ACT_REMOVE, 32'h0, 8'hFF);
    send_action(ACT_REMOVE, 32'h0, 8'h00);

    growing = 1'b0;
    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      no_idle <= (real_items >= 20 && real_items < 50);
      if (real_items == 60) begin
        drain();
        real_items++;
      end else if ($urandom_range(0, 99) < 5) begin
        send_action(ACT_SPARE_5 + 3'($urandom_range(0, 2)), $urandom(),
                    8'($urandom_range(0, 255)));
      end else begin
        if (sb.used == DEPTH_DEF) growing = 1'b0;
        else if (sb.used == 0) growing = 1'b1;
        w = pick_word(growing);
        send_word(w);
        real_items++;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("bounded_sequence_store_tb: clean");
    end else begin
      $display("bounded_sequence_store_tb: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("bounded_sequence_store_tb: errors");
    $finish;
  end

endmodule
